### hw/rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication checked on every rising clock edge out of reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked on every rising clock edge out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/uvst_pkg.sv
// types and codes for the unique value set table
`timescale 1ns / 1ps

package uvst_pkg;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_PRESENT = 2'd3;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 5;

    // search token moving along the cell chain
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic [VALUE_W-1:0] key;
        logic [VALUE_W-1:0] last;
    } uvst_link_t;

    // entry write broadcast to every cell
    typedef struct packed {
        logic               en;
        logic [VALUE_W-1:0] data;
    } uvst_wr_t;

endpackage

### hw/rtl/uvst_cell.sv
// one table slot: holds an entry and forwards the search token
`timescale 1ns / 1ps

module uvst_cell #(
    parameter int unsigned IDX   = 0,
    parameter int unsigned IDX_W = 4,
    parameter int unsigned CNT_W = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CNT_W-1:0]    count,
    input  uvst_pkg::uvst_wr_t  wr,
    input  logic [IDX_W-1:0]    wr_idx,
    input  uvst_pkg::uvst_link_t link_in,
    input  logic [IDX_W-1:0]    slot_in,
    output uvst_pkg::uvst_link_t link_out,
    output logic [IDX_W-1:0]    slot_out
);
    import uvst_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(IDX);
    localparam logic [CNT_W-1:0] MY_POS  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

    logic [VALUE_W-1:0] entry_reg;
    logic               valid_reg;
    logic               hit_reg;
    logic [VALUE_W-1:0] key_reg;
    logic [VALUE_W-1:0] last_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic               occupied;
    logic               match;
    logic               hit_next;
    logic [IDX_W-1:0]   slot_next;
    logic [VALUE_W-1:0] last_next;

    assign occupied  = MY_POS < count;
    assign match     = occupied && (entry_reg == link_in.key);
    assign hit_next  = link_in.hit | match;
    assign slot_next = link_in.hit ? slot_in : MY_IDX;
    assign last_next = (MY_NEXT == count) ? entry_reg : link_in.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= link_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg  <= hit_next;
        key_reg  <= link_in.key;
        last_reg <= last_next;
        slot_reg <= slot_next;
        if (wr.en && (wr_idx == MY_IDX)) begin
            entry_reg <= wr.data;
        end
    end

    assign link_out.valid = valid_reg;
    assign link_out.hit   = hit_reg;
    assign link_out.key   = key_reg;
    assign link_out.last  = last_reg;
    assign slot_out       = slot_reg;

endmodule

### hw/rtl/unique_value_set_table_top.sv
// top level of the unique value set table
`timescale 1ns / 1ps

// Bounded set of distinct 32-bit values. Each transfer on s_ is a lookup,
// insert or remove; each yields one transfer on m_ with a status and the new
// count. The search token walks a chain of CAPACITY cells, one cell per cycle,
// and the result is registered from the tail; no new input is taken while a
// search is under way. The next input may be taken in the same cycle a waiting
// result is transferred.

`include "assert_macros.svh"

module unique_value_set_table_top #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic signed [31:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [4:0]         m_count
);
    import uvst_pkg::*;

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_SEARCH = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         op_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic [4:0]         m_count_reg, m_count_next;
    logic [31:0]        count_ext;
    logic               s_fire;
    logic               finish;
    uvst_wr_t           wr;
    logic [IDX_W-1:0]   wr_idx;
    uvst_link_t         link [0:CAPACITY];
    logic [IDX_W-1:0]   slot_link [0:CAPACITY];
    uvst_link_t         tail;

    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;

    assign link[0].valid = s_fire;
    assign link[0].hit   = 1'b0;
    assign link[0].key   = $unsigned(s_value);
    assign link[0].last  = '0;
    assign slot_link[0]  = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        uvst_cell #(
            .IDX   (g),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .count    (count_reg),
            .wr       (wr),
            .wr_idx   (wr_idx),
            .link_in  (link[g]),
            .slot_in  (slot_link[g]),
            .link_out (link[g+1]),
            .slot_out (slot_link[g+1])
        );
    end

    assign tail   = link[CAPACITY];
    assign finish = (state_reg == S_SEARCH) && tail.valid;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        wr.en         = 1'b0;
        wr.data       = tail.key;
        wr_idx        = count_reg[IDX_W-1:0];
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (tail.valid) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                    unique case (op_reg)
                        OP_INSERT: begin
                            if (count_reg >= CAP_CNT) begin
                                m_status_next = ST_FULL;
                            end else if (tail.hit) begin
                                m_status_next = ST_PRESENT;
                            end else begin
                                wr.en         = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                                m_status_next = ST_DONE;
                            end
                        end
                        OP_REMOVE: begin
                            if (tail.hit) begin
                                wr.en         = 1'b1;
                                wr.data       = tail.last;
                                wr_idx        = slot_link[CAPACITY];
                                count_next    = count_reg - CNT_W'(1);
                                m_status_next = ST_DONE;
                            end else begin
                                m_status_next = ST_MISSING;
                            end
                        end
                        default: begin
                            m_status_next = tail.hit ? ST_DONE : ST_MISSING;
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign count_ext    = 32'(count_next);
    assign m_count_next = count_ext[4:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg <= s_op;
        end
        if (finish) begin
            m_status_reg <= m_status_next;
            m_count_reg  <= m_count_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_count  = m_count_reg;

    `ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CAP_CNT)
    `ASSERT_SAME(a_tail_in_search, aclk, aresetn, tail.valid, state_reg == S_SEARCH)
    `ASSERT_NEXT(a_accept_clears_out, aclk, aresetn, s_fire, (state_reg == S_SEARCH) && !m_valid_reg)
    `ASSERT_NEXT(a_finish_shows_result, aclk, aresetn, finish, m_valid_reg && (state_reg == S_IDLE))

endmodule

### verif/tb_unique_value_set_table_top.sv
// testbench for the unique value set table: directed and random lookup, insert, remove traffic
`timescale 1ns / 1ps

module tb_unique_value_set_table_top;
    import uvst_pkg::*;

    localparam int unsigned CAPACITY   = 16;
    localparam logic [1:0]  OP_SPARE   = 2'd3;
    localparam int          QUIET_MAX  = 5000;
    localparam int          POOL_SIZE  = 24;
    localparam logic [31:0] VAL_MIN    = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_ZERO   = 32'h0000_0000;
    localparam logic [31:0] VAL_ONES   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] count;
    } set_outcome_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_op    = OP_LOOKUP;
    logic signed [31:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic [4:0]         m_count;

    logic [31:0]  set_slots [CAPACITY];
    int unsigned  set_fill = 0;
    set_outcome_t pending_outcomes [$];
    logic [31:0]  value_pool [POOL_SIZE];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    unique_value_set_table_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .s_value (s_value),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_status(m_status),
        .m_count (m_count)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 40) begin
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    // updates the set and queues the outcome of one accepted transfer
    task automatic apply_set_op(input logic [1:0] op, input logic [31:0] val);
        set_outcome_t outcome;
        bit           found;
        int unsigned  hit_slot;
        found    = 1'b0;
        hit_slot = 0;
        for (int unsigned k = 0; k < set_fill; k++) begin
            if (!found && set_slots[k] == val) begin
                found    = 1'b1;
                hit_slot = k;
            end
        end
        case (op)
            OP_INSERT: begin
                if (set_fill >= CAPACITY) begin
                    outcome.status = ST_FULL;
                end else if (found) begin
                    outcome.status = ST_PRESENT;
                end else begin
                    set_slots[set_fill] = val;
                    set_fill++;
                    outcome.status = ST_DONE;
                end
            end
            OP_REMOVE: begin
                if (found) begin
                    set_slots[hit_slot] = set_slots[set_fill - 1];
                    set_fill--;
                    outcome.status = ST_DONE;
                end else begin
                    outcome.status = ST_MISSING;
                end
            end
            default: begin
                outcome.status = found ? ST_DONE : ST_MISSING;
            end
        endcase
        outcome.count = set_fill[4:0];
        pending_outcomes.push_back(outcome);
    endtask

    // called and returns just after a falling edge; valid stays high on return
    task automatic send_item(input logic [1:0] op, input logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_value <= val;
        do @(posedge aclk); while (!s_ready);
        apply_set_op(op, val);
        @(negedge aclk);
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(negedge aclk);
    endtask

    // result checking
    always @(posedge aclk) begin
        set_outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected result, status", m_status, 0);
            end else begin
                want = pending_outcomes.pop_front();
                if (m_status !== want.status) report_mismatch("status", m_status, want.status);
                if (m_count !== want.count) report_mismatch("count", m_count, want.count);
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_MAX) begin
            $display("watchdog expired after %0d idle cycles", quiet_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_basic_ops();
        send_item(OP_LOOKUP, VAL_ZERO);
        send_item(OP_REMOVE, VAL_MIN);
        send_item(OP_INSERT, VAL_MIN);
        send_item(OP_INSERT, VAL_MAX);
        send_item(OP_INSERT, VAL_ZERO);
        send_item(OP_INSERT, VAL_ONES);
        send_item(OP_INSERT, VAL_MAX);
        send_item(OP_LOOKUP, VAL_MAX);
        send_item(OP_LOOKUP, 32'd1);
        send_item(OP_SPARE, VAL_MIN);
        send_item(OP_SPARE, 32'd5);
        // last stored entry removed, then the first one with a swap
        send_item(OP_REMOVE, VAL_ONES);
        send_item(OP_REMOVE, VAL_MIN);
        send_item(OP_REMOVE, 32'd7);
        send_item(OP_LOOKUP, VAL_ZERO);
        wait_all_results();
    endtask

    task automatic test_full_table();
        for (int k = 0; k < CAPACITY; k++) begin
            send_item(OP_INSERT, 32'h1000_0000 + k);
        end
        send_item(OP_INSERT, 32'h1000_0003);
        send_item(OP_INSERT, 32'h2000_0000);
        send_item(OP_REMOVE, 32'h1000_0000);
        wait_all_results();
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct, input int n_items);
        int          r;
        int          ins_pct;
        int          rem_pct;
        logic [1:0]  op;
        logic [31:0] val;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < POOL_SIZE; i++) begin
            case (i % 4)
                0: value_pool[i] = $urandom();
                1: value_pool[i] = VAL_MIN + $urandom_range(7);
                2: value_pool[i] = VAL_MAX - $urandom_range(7);
                default: value_pool[i] = $urandom_range(15);
            endcase
        end
        for (int n = 0; n < n_items; n++) begin
            // alternate between filling and draining the set
            if ((n / 60) % 2 == 0) begin
                ins_pct = 55;
                rem_pct = 20;
            end else begin
                ins_pct = 25;
                rem_pct = 50;
            end
            r = $urandom_range(99);
            if (r < ins_pct) op = OP_INSERT;
            else if (r < ins_pct + rem_pct) op = OP_REMOVE;
            else if (r < 95) op = OP_LOOKUP;
            else op = OP_SPARE;
            if ($urandom_range(99) < 80) val = value_pool[$urandom_range(POOL_SIZE - 1)];
            else val = $urandom();
            send_item(op, val);
            if ($urandom_range(99) == 0) wait_all_results();
        end
        wait_all_results();
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_basic_ops();
        test_full_table();
        random_phase(0, 0, 360);
        random_phase(76, 0, 360);
        random_phase(0, 76, 360);
        random_phase(10, 10, 360);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_all_results();
        repeat (2 * (CAPACITY + 1)) @(negedge aclk);
        if (pending_outcomes.size() != 0) begin
            report_mismatch("results never delivered", 0, pending_outcomes.size());
        end
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/uvst_pkg.sv
hw/rtl/uvst_cell.sv
hw/rtl/unique_value_set_table_top.sv
verif/tb_unique_value_set_table_top.sv
